/* rtl/spg_pkg.sv */
package spg_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_MOTOR_ENABLE    = 3'd0,
        REG_TARGET_VELOCITY = 3'd1,
        REG_TARGET_ACCEL    = 3'd2,
        REG_TIMER_TICK      = 3'd3,
        REG_PERIOD_LIMIT    = 3'd4
    } spg_reg_idx_t;

    localparam int CFG_DATA_W = 31;

    localparam logic signed [31:0] STEP_D_Q17    = 32'sd54817;
    localparam logic signed [31:0] STEP_100D_Q17 = 32'sd548175872;
    localparam logic signed [31:0] PRD_MIN_Q14   = 32'sd163840000;
    localparam logic signed [31:0] PRD_MIN_Q13   = 32'sd81920000;
    localparam logic signed [31:0] HUNDREDTH_Q21 = 32'sd20971;
    localparam logic signed [31:0] HUNDREDTH_Q27 = 32'sd1342177;

    localparam logic signed [31:0] STEP_PERIOD_RST = 32'sd1073725440;
    localparam logic [15:0]        PERIOD_LIMIT_RST = 16'd65535;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    // highest even power of two covering a 48 bit root argument
    localparam logic [63:0] SQRT_TOP = 64'h0000_4000_0000_0000;

    // q shifts used by the datapath
    localparam logic [4:0] SH_14 = 5'd14;
    localparam logic [4:0] SH_15 = 5'd15;
    localparam logic [4:0] SH_17 = 5'd17;
    localparam logic [4:0] SH_21 = 5'd21;
    localparam logic [4:0] SH_25 = 5'd25;
    localparam logic [4:0] SH_27 = 5'd27;
    localparam logic [4:0] SH_29 = 5'd29;
    localparam logic [4:0] SH_5  = 5'd5;

    // control of the iterative divide / root unit
    typedef struct packed {
        logic       start;
        logic       is_sqrt;
        logic [4:0] shift;
    } spg_iter_ctl_t;

endpackage

/* rtl/spg_if.sv */
interface spg_step_if;
    logic        valid;
    logic        ready;
    logic [29:0] handle_gain;

    modport source (output valid, output handle_gain, input ready);
    modport sink   (input valid, input handle_gain, output ready);
endinterface

interface spg_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        pwm_period;
    logic [15:0]        pwm_compare;
    logic [30:0]        next_velocity;
    logic [30:0]        step_distance;
    logic signed [31:0] total_distance;

    modport source (output valid, output pwm_period, output pwm_compare,
                    output next_velocity, output step_distance,
                    output total_distance, input ready);
    modport sink   (input valid, input pwm_period, input pwm_compare,
                    input next_velocity, input step_distance,
                    input total_distance, output ready);
endinterface

/* rtl/spg_mul.sv */
module spg_mul
    import spg_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    input  logic [4:0]         shift,
    output logic signed [31:0] res
);

    logic signed [63:0] prod_reg;
    logic [4:0]         shift_reg;
    logic signed [63:0] shifted;

    always_ff @(posedge clk)
    begin
        prod_reg  <= op_a * op_b;
        shift_reg <= shift;
    end

    // floor shift then keep the low word
    assign shifted = prod_reg >>> shift_reg;
    assign res     = $signed(shifted[31:0]);

endmodule

/* rtl/spg_iter.sv */
module spg_iter
    import spg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  spg_iter_ctl_t      ctl,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic               done,
    output logic signed [31:0] res
);

    typedef enum logic [3:0] {
        U_IDLE  = 4'b0001,
        U_SETUP = 4'b0010,
        U_RUN   = 4'b0100,
        U_FIN   = 4'b1000
    } spg_unit_state_t;

    spg_unit_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic        sqrt_reg, neg_reg, aneg_reg, zero_reg, sat_reg;
    logic [4:0]  shift_reg;
    logic [31:0] ua_reg, ub_reg;
    logic [63:0] rem_reg, step_reg, acc_reg;

    logic [63:0] num;
    logic [63:0] trial;
    logic        sat;

    assign num   = {32'd0, ua_reg} << shift_reg;
    assign sat   = num >= {1'b0, ub_reg, 31'd0};
    assign trial = sqrt_reg ? (acc_reg + step_reg) : step_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                    state_next = U_SETUP;
            end
            U_SETUP:
            begin
                cnt_next = sqrt_reg ? 5'd23 : 5'd30;
                if (!sqrt_reg && (zero_reg || sat))
                    state_next = U_FIN;
                else
                    state_next = U_RUN;
            end
            U_RUN:
            begin
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = U_FIN;
            end
            U_FIN:   state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                begin
                    sqrt_reg  <= ctl.is_sqrt;
                    shift_reg <= ctl.shift;
                    neg_reg   <= op_a[31] != op_b[31];
                    aneg_reg  <= op_a[31];
                    zero_reg  <= op_b == 32'sd0;
                    ub_reg    <= op_b[31] ? 32'(-op_b) : 32'(op_b);
                    if (ctl.is_sqrt)
                        ua_reg <= (op_a > 32'sd0) ? 32'(op_a) : 32'd0;
                    else
                        ua_reg <= op_a[31] ? 32'(-op_a) : 32'(op_a);
                end
            end
            U_SETUP:
            begin
                rem_reg  <= num;
                acc_reg  <= 64'd0;
                sat_reg  <= sat;
                step_reg <= sqrt_reg ? SQRT_TOP : {2'b00, ub_reg, 30'd0};
            end
            U_RUN:
            begin
                if (sqrt_reg)
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg <= rem_reg - trial;
                        acc_reg <= (acc_reg >> 1) + step_reg;
                    end
                    else
                        acc_reg <= acc_reg >> 1;
                    step_reg <= step_reg >> 2;
                end
                else
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg <= rem_reg - trial;
                        acc_reg <= {acc_reg[62:0], 1'b1};
                    end
                    else
                        acc_reg <= {acc_reg[62:0], 1'b0};
                    step_reg <= step_reg >> 1;
                end
            end
            default: ;
        endcase
    end

    assign done = state_reg == U_FIN;

    always_comb
    begin
        if (sqrt_reg)
            res = $signed(acc_reg[31:0]);
        else if (zero_reg)
            res = aneg_reg ? INT_MIN : INT_MAX;
        else if (sat_reg)
            res = neg_reg ? INT_MIN : INT_MAX;
        else if (neg_reg)
            res = -$signed(acc_reg[31:0]);
        else
            res = $signed(acc_reg[31:0]);
    end

endmodule

/* rtl/stepper_accel_period_generator.sv */
// channel  | direction | payload                                         | handshake
// step     | in        | handle_gain                                     | valid / ready
// result   | out       | pwm_period pwm_compare next_velocity            | valid / ready
//          |           | step_distance total_distance                    |
// cfg      | in        | cfg_index cfg_data                              | cfg_we only
//
// one request runs from acceptance to result valid through the sequencer states:
// three divides of 31 restoring steps and two roots of 24 steps in the shared
// iterative unit, plus the sequencer and multiplier states; a divide that saturates
// or meets a zero divisor goes from its setup state straight to its final state
// step.ready is high only while the sequencer is idle; a disabled motor drops the
// request in the cycle it is taken
// a result waiting in the output register lets the next request run up to its last
// state, where it holds until the sink takes the earlier one
// rst_n is asynchronous, active low; step_period and distance_sum come back at once
module stepper_accel_period_generator
    import spg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    spg_step_if.sink              step,
    spg_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // one-hot sequencer: M_ states feed the multiplier, D_ and SQ states the
    // divide / root unit, _W states wait for it
    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_M_T1    = 22'h000002,
        S_M_PTS   = 22'h000004,
        S_D_ROLLS = 22'h000008,
        S_W_ROLLS = 22'h000010,
        S_M_R100  = 22'h000020,
        S_M_RUN   = 22'h000040,
        S_D_VEL   = 22'h000080,
        S_W_VEL   = 22'h000100,
        S_M_ACC   = 22'h000200,
        S_M_VV    = 22'h000400,
        S_SQ1     = 22'h000800,
        S_W_SQ1   = 22'h001000,
        S_M_M     = 22'h002000,
        S_D_Q     = 22'h004000,
        S_W_Q     = 22'h008000,
        S_SQ2     = 22'h010000,
        S_W_SQ2   = 22'h020000,
        S_M_PN    = 22'h040000,
        S_M_PH    = 22'h080000,
        S_PH      = 22'h100000,
        S_EMIT    = 22'h200000
    } spg_state_t;

    spg_state_t state_reg, state_next;

    // configuration registers
    logic        en_reg;
    logic [30:0] tv_reg, ta_reg, tt_reg;
    logic [15:0] lim_reg;

    // architectural state
    logic signed [31:0] sp_reg, sp_next;
    logic signed [31:0] dsum_reg, dsum_next;

    // working registers of one request
    logic [29:0]        gain_reg, gain_next;
    logic signed [31:0] pts_reg, pts_next;
    logic signed [31:0] rolls_reg, rolls_next;
    logic signed [31:0] r100_reg, r100_next;
    logic signed [31:0] run_reg, run_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] nv_reg, nv_next;
    logic signed [31:0] q_reg, q_next;
    logic signed [31:0] pnts_reg, pnts_next;
    logic signed [31:0] ph_reg, ph_next;

    // output register
    logic               ov_reg, ov_next;
    logic [15:0]        oper_reg, oper_next;
    logic [15:0]        ocmp_reg, ocmp_next;
    logic [30:0]        onv_reg, onv_next;
    logic [30:0]        orun_reg, orun_next;

    // shared units
    logic signed [31:0] mul_a, mul_b, mul_res;
    logic [4:0]         mul_sh;
    spg_iter_ctl_t      it_ctl;
    logic signed [31:0] it_a, it_b, it_res;
    logic               it_done;

    // combinational helpers
    logic signed [31:0] lim14, lim13;
    logic signed [31:0] acc10, arg_diff, arg;
    logic signed [31:0] pn_clamp, ph_clamp;
    logic [15:0]        per;

    spg_mul u_mul
    (
        .clk   (clk),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .shift (mul_sh),
        .res   (mul_res)
    );

    spg_iter u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (it_ctl),
        .op_a  (it_a),
        .op_b  (it_b),
        .done  (it_done),
        .res   (it_res)
    );

    assign lim14 = $signed({2'b00, lim_reg, 14'd0});
    assign lim13 = $signed({3'b000, lim_reg, 13'd0});

    // next speed argument: accelerate while below target, else decelerate
    // and fold a negative difference back to its magnitude
    assign acc10    = acc_reg >>> 10;
    assign arg_diff = mul_res - acc10;
    always_comb
    begin
        if (vel_reg < $signed({1'b0, tv_reg}))
            arg = acc10 + mul_res;
        else if (arg_diff < 32'sd0)
            arg = -arg_diff;
        else
            arg = arg_diff;
    end

    // upper bound tested first, so a low limit wins over the floor
    always_comb
    begin
        if (mul_res > lim14)
            pn_clamp = lim14;
        else if (mul_res < PRD_MIN_Q14)
            pn_clamp = PRD_MIN_Q14;
        else
            pn_clamp = mul_res;
        if (mul_res > lim13)
            ph_clamp = lim13;
        else if (mul_res < PRD_MIN_Q13)
            ph_clamp = PRD_MIN_Q13;
        else
            ph_clamp = mul_res;
    end

    assign per = ph_reg[28:13];

    assign step.ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        dsum_next  = dsum_reg;
        gain_next  = gain_reg;
        pts_next   = pts_reg;
        rolls_next = rolls_reg;
        r100_next  = r100_reg;
        run_next   = run_reg;
        vel_next   = vel_reg;
        acc_next   = acc_reg;
        nv_next    = nv_reg;
        q_next     = q_reg;
        pnts_next  = pnts_reg;
        ph_next    = ph_reg;
        oper_next  = oper_reg;
        ocmp_next  = ocmp_reg;
        onv_next   = onv_reg;
        orun_next  = orun_reg;
        ov_next    = ov_reg && !result.ready;

        mul_a  = 32'sd0;
        mul_b  = 32'sd0;
        mul_sh = 5'd0;
        it_ctl = '0;
        it_a   = 32'sd0;
        it_b   = 32'sd0;

        case (state_reg)
            S_IDLE:
            begin
                if (step.valid && en_reg)
                begin
                    gain_next  = step.handle_gain;
                    state_next = S_M_T1;
                end
            end
            S_M_T1:
            begin
                mul_a      = HUNDREDTH_Q21;
                mul_b      = sp_reg;
                mul_sh     = SH_14;
                state_next = S_M_PTS;
            end
            S_M_PTS:
            begin
                mul_a      = mul_res;
                mul_b      = HUNDREDTH_Q27;
                mul_sh     = SH_21;
                state_next = S_D_ROLLS;
            end
            S_D_ROLLS:
            begin
                // timer rolls per step time
                pts_next     = mul_res;
                it_ctl.start = 1'b1;
                it_ctl.shift = SH_27;
                it_a         = $signed({1'b0, tt_reg});
                it_b         = mul_res;
                state_next   = S_W_ROLLS;
            end
            S_W_ROLLS:
            begin
                if (it_done)
                begin
                    rolls_next = it_res;
                    state_next = S_M_R100;
                end
            end
            S_M_R100:
            begin
                mul_a      = STEP_100D_Q17;
                mul_b      = rolls_reg;
                mul_sh     = SH_27;
                state_next = S_M_RUN;
            end
            S_M_RUN:
            begin
                r100_next  = mul_res;
                mul_a      = STEP_D_Q17;
                mul_b      = rolls_reg;
                mul_sh     = SH_27;
                state_next = S_D_VEL;
            end
            S_D_VEL:
            begin
                // present speed from distance over time
                run_next     = mul_res;
                it_ctl.start = 1'b1;
                it_ctl.shift = SH_17;
                it_a         = r100_reg;
                it_b         = pts_reg >>> 10;
                state_next   = S_W_VEL;
            end
            S_W_VEL:
            begin
                if (it_done)
                begin
                    vel_next   = it_res >>> 2;
                    state_next = S_M_ACC;
                end
            end
            S_M_ACC:
            begin
                mul_a      = run_reg >>> 2;
                mul_b      = $signed({1'b0, ta_reg});
                mul_sh     = SH_15;
                state_next = S_M_VV;
            end
            S_M_VV:
            begin
                acc_next   = mul_res <<< 1;
                mul_a      = vel_reg;
                mul_b      = vel_reg;
                mul_sh     = SH_25;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                it_ctl.start   = 1'b1;
                it_ctl.is_sqrt = 1'b1;
                it_ctl.shift   = SH_5;
                it_a           = arg;
                state_next     = S_W_SQ1;
            end
            S_W_SQ1:
            begin
                if (it_done)
                begin
                    nv_next    = it_res <<< 10;
                    state_next = S_M_M;
                end
            end
            S_M_M:
            begin
                mul_a      = STEP_100D_Q17;
                mul_b      = $signed({1'b0, tt_reg});
                mul_sh     = SH_27;
                state_next = S_D_Q;
            end
            S_D_Q:
            begin
                it_ctl.start = 1'b1;
                it_ctl.shift = SH_17;
                it_a         = mul_res;
                it_b         = nv_reg <<< 2;
                state_next   = S_W_Q;
            end
            S_W_Q:
            begin
                if (it_done)
                begin
                    q_next     = it_res;
                    state_next = S_SQ2;
                end
            end
            S_SQ2:
            begin
                it_ctl.start   = 1'b1;
                it_ctl.is_sqrt = 1'b1;
                it_ctl.shift   = SH_17;
                it_a           = q_reg;
                state_next     = S_W_SQ2;
            end
            S_W_SQ2:
            begin
                if (it_done)
                begin
                    pnts_next  = it_res;
                    state_next = S_M_PN;
                end
            end
            S_M_PN:
            begin
                mul_a      = PRD_MIN_Q14;
                mul_b      = pnts_reg;
                mul_sh     = SH_17;
                state_next = S_M_PH;
            end
            S_M_PH:
            begin
                sp_next    = pn_clamp;
                mul_a      = pn_clamp;
                mul_b      = $signed({2'b00, gain_reg});
                mul_sh     = SH_29;
                state_next = S_PH;
            end
            S_PH:
            begin
                ph_next    = ph_clamp;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ov_reg || result.ready)
                begin
                    ov_next    = 1'b1;
                    oper_next  = per;
                    ocmp_next  = {1'b0, per[15:1]} + {2'b00, per[15:2]};
                    onv_next   = nv_reg[30:0];
                    orun_next  = run_reg[30:0];
                    dsum_next  = dsum_reg + run_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            sp_reg    <= STEP_PERIOD_RST;
            dsum_reg  <= 32'sd0;
            en_reg    <= 1'b0;
            tv_reg    <= 31'd0;
            ta_reg    <= 31'd0;
            tt_reg    <= 31'd0;
            lim_reg   <= PERIOD_LIMIT_RST;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            sp_reg    <= sp_next;
            dsum_reg  <= dsum_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MOTOR_ENABLE:    en_reg  <= cfg_data[0];
                    REG_TARGET_VELOCITY: tv_reg  <= cfg_data[30:0];
                    REG_TARGET_ACCEL:    ta_reg  <= cfg_data[30:0];
                    REG_TIMER_TICK:      tt_reg  <= cfg_data[30:0];
                    REG_PERIOD_LIMIT:    lim_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        gain_reg  <= gain_next;
        pts_reg   <= pts_next;
        rolls_reg <= rolls_next;
        r100_reg  <= r100_next;
        run_reg   <= run_next;
        vel_reg   <= vel_next;
        acc_reg   <= acc_next;
        nv_reg    <= nv_next;
        q_reg     <= q_next;
        pnts_reg  <= pnts_next;
        ph_reg    <= ph_next;
        oper_reg  <= oper_next;
        ocmp_reg  <= ocmp_next;
        onv_reg   <= onv_next;
        orun_reg  <= orun_next;
    end

    assign result.valid          = ov_reg;
    assign result.pwm_period     = oper_reg;
    assign result.pwm_compare    = ocmp_reg;
    assign result.next_velocity  = onv_reg;
    assign result.step_distance  = orun_reg;
    assign result.total_distance = dsum_reg;

endmodule

/* rtl/spg_checker.sv */
module spg_checker
    import spg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [15:0]        period,
    input logic [15:0]        compare,
    input logic signed [31:0] total
);

    // a pending result stays up until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(period) && $stable(total))
        else $error("stalled result changed");

    // the work of a request spans many cycles
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared right after a request");

    // three quarter duty
    a_compare: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> compare == ({1'b0, period[15:1]} + {2'b00, period[15:2]}))
        else $error("compare does not match period");

endmodule

bind stepper_accel_period_generator spg_checker u_spg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (step.valid),
    .in_ready  (step.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .period    (result.pwm_period),
    .compare   (result.pwm_compare),
    .total     (result.total_distance)
);

/* test/spg_tb_if.sv */
interface spg_cfg_bus;
    logic        we;
    logic [2:0]  index;
    logic [30:0] data;
endinterface

/* test/spg_scoreboard.sv */
module spg_scoreboard
    import spg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_valid,
    input  logic        step_ready,
    input  logic [29:0] step_gain,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [15:0] res_period,
    input  logic [15:0] res_compare,
    input  logic [30:0] res_velocity,
    input  logic [30:0] res_step_dist,
    input  logic [31:0] res_total_dist,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] compare;
        logic [30:0] velocity;
        logic [30:0] step_dist;
        logic [31:0] total_dist;
    } motion_t;

    motion_t planned_q[$];

    logic        enable;
    logic [30:0] tgt_vel;
    logic [30:0] tgt_acc;
    logic [30:0] tick;
    logic [15:0] limit;
    logic signed [31:0] cur_period;
    logic [31:0] travelled;

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                  logic signed [31:0] b, int s);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'(p >>> s);
    endfunction

    function automatic logic signed [31:0] fx_div(logic signed [31:0] a,
                                                  logic signed [31:0] b, int q);
        logic [63:0] ua, ub, qv;
        logic neg;
        if (b == 0)
            return (a >= 0) ? INT_MAX : INT_MIN;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-64'(a)) : 64'(a);
        ub = (b < 0) ? 64'(-64'(b)) : 64'(b);
        qv = (ua << q) / ub;
        if (neg)
            return (qv >= 64'h8000_0000) ? INT_MIN : 32'(-qv);
        return (qv > 64'h7FFF_FFFF) ? INT_MAX : 32'(qv);
    endfunction

    function automatic logic signed [31:0] fx_root(logic signed [31:0] a, int q);
        logic [63:0] x, r, b;
        if (a <= 0)
            return 0;
        x = 64'(a) << q;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return 32'(r);
    endfunction

    // one step of the speed profile, updates period and distance state
    function automatic motion_t plan_step(logic [29:0] gain_in);
        logic signed [31:0] lim14, lim13, t1, pts, rolls, run100, run, vel, acc;
        logic signed [31:0] vv, arg, nv, pnts, pn, ph, gain;
        motion_t m;
        gain  = 32'(gain_in);
        lim14 = 32'(limit) << 14;
        lim13 = 32'(limit) << 13;
        t1     = fx_mul(HUNDREDTH_Q21, cur_period, 14);
        pts    = fx_mul(t1, HUNDREDTH_Q27, 21);
        rolls  = fx_div(32'(tick), pts, 27);
        run100 = fx_mul(STEP_100D_Q17, rolls, 27);
        run    = fx_mul(STEP_D_Q17, rolls, 27);
        vel    = fx_div(run100, pts >>> 10, 17) >>> 2;
        acc    = fx_mul(run >>> 2, 32'(tgt_acc), 15) << 1;
        vv     = fx_mul(vel, vel, 25);
        if (vel < $signed(32'(tgt_vel)))
            arg = (acc >>> 10) + vv;
        else
        begin
            arg = vv - (acc >>> 10);
            if (arg < 0)
                arg = -arg;
        end
        nv   = fx_root(arg, 5) << 10;
        pnts = fx_root(fx_div(fx_mul(STEP_100D_Q17, 32'(tick), 27), nv << 2, 17), 17);
        pn   = fx_mul(PRD_MIN_Q14, pnts, 17);
        if (pn > lim14)
            pn = lim14;
        else if (pn < PRD_MIN_Q14)
            pn = PRD_MIN_Q14;
        cur_period = pn;
        ph = fx_mul(pn, gain, 29);
        if (ph > lim13)
            ph = lim13;
        else if (ph < PRD_MIN_Q13)
            ph = PRD_MIN_Q13;
        travelled = travelled + run;
        m.period     = 16'(ph >> 13);
        m.compare    = (m.period >> 1) + (m.period >> 2);
        m.velocity   = nv[30:0];
        m.step_dist  = run[30:0];
        m.total_dist = travelled;
        return m;
    endfunction

    assign pending = planned_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        motion_t want;
        if (!rst_n)
        begin
            enable     <= 1'b0;
            tgt_vel    <= '0;
            tgt_acc    <= '0;
            tick       <= '0;
            limit      <= PERIOD_LIMIT_RST;
            cur_period <= STEP_PERIOD_RST;
            travelled  <= '0;
            errors     <= 0;
            planned_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MOTOR_ENABLE:    enable  <= cfg_data[0];
                    REG_TARGET_VELOCITY: tgt_vel <= cfg_data;
                    REG_TARGET_ACCEL:    tgt_acc <= cfg_data;
                    REG_TIMER_TICK:      tick    <= cfg_data;
                    REG_PERIOD_LIMIT:    limit   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (step_valid && step_ready && enable)
                planned_q.push_back(plan_step(step_gain));
            if (res_valid && res_ready)
            begin
                if (planned_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h %h %h %h %h",
                             $time, res_period, res_compare, res_velocity,
                             res_step_dist, res_total_dist);
                    errors <= errors + 1;
                end
                else
                begin
                    want = planned_q.pop_front();
                    if (want !== {res_period, res_compare, res_velocity,
                                  res_step_dist, res_total_dist})
                    begin
                        $display("%0t: mismatch expected %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 $time, want.period, want.compare, want.velocity,
                                 want.step_dist, $signed(want.total_dist), res_period,
                                 res_compare, res_velocity, res_step_dist,
                                 $signed(res_total_dist));
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/tb.sv */
module tb;
    import spg_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   hold_sink;
    bit   stall_on;

    spg_step_if   step ();
    spg_result_if result ();
    spg_cfg_bus   cfg ();

    stepper_accel_period_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step.sink),
        .result    (result.source),
        .cfg_we    (cfg.we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data)
    );

    // watches both channels and the register port, predicts and compares
    spg_scoreboard checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_valid     (step.valid),
        .step_ready     (step.ready),
        .step_gain      (step.handle_gain),
        .res_valid      (result.valid),
        .res_ready      (result.ready),
        .res_period     (result.pwm_period),
        .res_compare    (result.pwm_compare),
        .res_velocity   (result.next_velocity),
        .res_step_dist  (result.step_distance),
        .res_total_dist (result.total_distance),
        .cfg_we         (cfg.we),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .errors         (errors),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, the odd long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // receiver side: random stalls, plus a long hold-off on request
    initial
    begin
        int n;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                result.ready <= 1'b0;
                repeat (2000) @(posedge clk);
                hold_sink = 0;
            end
            if (stall_on)
                n = gap_len();
            else
                n = 0;
            if (n == 0)
                result.ready <= 1'b1;
            else
            begin
                result.ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
        end
    end

    // cycle limit: the slowest run is ~1000 requests with the longest stalls and gaps
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("[stepper_accel_period_generator] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(spg_reg_idx_t idx, logic [30:0] value);
        cfg.we    <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        cfg.we    <= 1'b0;
    endtask

    // offer one request, hold it until taken
    task automatic send_step(logic [29:0] gain, bit with_gap);
        int g;
        if (with_gap)
        begin
            g = gap_len();
            if (g > 0)
            begin
                step.valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
        step.valid       <= 1'b1;
        step.handle_gain <= gain;
        @(posedge clk);
        while (!step.ready)
            @(posedge clk);
    endtask

    // drain everything, then let a dropped or in-flight request finish
    task automatic settle();
        step.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_setup();
        int r;
        r = $urandom_range(0, 9);
        write_reg(REG_TIMER_TICK, (r == 0) ? 31'h7FFF_FFFF :
                  (r == 1) ? 31'd0 : 31'($urandom_range(100000, 40000000)));
        r = $urandom_range(0, 9);
        write_reg(REG_TARGET_VELOCITY, (r == 0) ? 31'h7FFF_FFFF :
                  (r == 1) ? 31'd0 : 31'($urandom_range(0, 31'h7FFF_FFFF)));
        r = $urandom_range(0, 9);
        write_reg(REG_TARGET_ACCEL, (r == 0) ? 31'h7FFF_FFFF :
                  (r == 1) ? 31'd0 : 31'($urandom_range(0, 31'h7FFF_FFFF)));
        r = $urandom_range(0, 9);
        write_reg(REG_PERIOD_LIMIT, (r == 0) ? 31'd65535 : (r == 1) ? 31'd10000 :
                  (r == 2) ? 31'($urandom_range(0, 9999)) : 31'($urandom_range(10000, 65535)));
        write_reg(REG_MOTOR_ENABLE, ($urandom_range(0, 7) != 0) ? 31'd1 : 31'd0);
    endtask

    function automatic logic [29:0] rand_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 30'd268435456;
        if (r == 1)
            return 30'd536870912;
        if (r == 2)
            return 30'($urandom());
        return 30'($urandom_range(0, 536870912));
    endfunction

    initial
    begin
        logic [29:0] edge_gains [6];
        edge_gains = '{30'd0, 30'd1, 30'd268435456, 30'd536870912,
                       30'h3FFF_FFFF, 30'h2AAA_AAAA};
        hold_sink        = 0;
        stall_on         = 0;
        rst_n            = 1'b0;
        step.valid       <= 1'b0;
        step.handle_gain <= '0;
        cfg.we           <= 1'b0;
        cfg.index        <= REG_MOTOR_ENABLE;
        cfg.data         <= '0;
        repeat (7) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // disabled motor: requests are dropped
        send_step(30'd268435456, 0);
        send_step(30'h3FFF_FFFF, 0);
        settle();

        // enabled with all-zero rates: zero divisor and zero root paths
        write_reg(REG_MOTOR_ENABLE, 31'd1);
        foreach (edge_gains[i])
            send_step(edge_gains[i], 0);
        settle();

        // typical profile, then extremes of the tick, velocity, acceleration and limit registers
        write_reg(REG_TIMER_TICK, 31'd10000000);
        write_reg(REG_TARGET_VELOCITY, 31'd300000000);
        write_reg(REG_TARGET_ACCEL, 31'd50000000);
        foreach (edge_gains[i])
            send_step(edge_gains[i], 0);
        settle();
        write_reg(REG_TIMER_TICK, 31'h7FFF_FFFF);
        write_reg(REG_TARGET_ACCEL, 31'h7FFF_FFFF);
        write_reg(REG_TARGET_VELOCITY, 31'h7FFF_FFFF);
        write_reg(REG_PERIOD_LIMIT, 31'd5000);
        repeat (4) send_step(30'd268435456, 0);
        settle();
        write_reg(REG_TARGET_VELOCITY, 31'd0);
        write_reg(REG_PERIOD_LIMIT, 31'd0);
        repeat (3) send_step(30'd536870912, 0);
        settle();

        // random phases with random idling on both sides
        stall_on = 1;
        for (int phase = 0; phase < 30; phase++)
        begin
            random_setup();
            if (phase == 3)
                hold_sink = 1;
            for (int k = 0; k < 30; k++)
            begin
                send_step(rand_gain(), phase % 4 != 1);
                if (phase == 6 && k == 15)
                    settle();
            end
            settle();
        end
        stall_on = 0;

        if (errors == 0)
            $display("[stepper_accel_period_generator] OK");
        else
            $display("[stepper_accel_period_generator] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/spg_pkg.sv
rtl/spg_if.sv
rtl/spg_mul.sv
rtl/spg_iter.sv
rtl/stepper_accel_period_generator.sv
rtl/spg_checker.sv
test/spg_tb_if.sv
test/spg_scoreboard.sv
test/tb.sv
